// ----- rtl/assert_macros.svh -----
// assertion macros used by positional_list_engine_unit
// no dependencies; clock and reset names follow the project ports
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define PLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/plm_pkg.sv -----
// types and codes of the positional list engine
// no dependencies
`default_nettype none

package plm_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_REMOVE  = 2'd2,
    FUNC_REVERSE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    status_e            status;
  } out_word_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/plm_cell.sv -----
// one storage cell of the list chain
// depends on plm_pkg
`default_nettype none

module plm_cell import plm_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [IDX_W-1:0]   slot_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]      data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic signed [31:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MyIdx > slot_i) begin
        data_d = left_i;
      end else if (MyIdx == slot_i) begin
        data_d = value_i;
      end
    end else if (ctrl_i.rem && (MyIdx >= slot_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/positional_list_engine_unit.sv -----
// Positional list engine: an ordered list of up to CAPACITY signed words held
// in a chain of cells, one word per cell. Insert and remove shift every cell at
// or past the slot by one place toward its neighbor; reverse only flips an order
// flag that mirrors later positions. busy_o stays low, so a word is accepted
// whenever start_i is high, and the result shows on result_o with done_o high
// for exactly the cycle after acceptance. The receiver cannot stall,
// so it must take the result in that cycle.
// depends on plm_pkg, plm_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine_unit import plm_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_word_t in_word_i,
  output logic          busy_o,
  output logic          done_o,
  output out_word_t     result_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [5:0] Cap6 = 6'(CAPACITY);

  logic [CNT_W-1:0] count_d, count_q;
  logic             rev_d, rev_q;
  logic             done_d, done_q;
  out_word_t        result_d, result_q;

  logic               accept;
  logic [5:0]         pos6, cnt6, ins_slot6, acc_slot6;
  logic               ins_pos_ok, acc_pos_ok, full;
  cell_ctrl_t         ctrl;
  logic [IDX_W-1:0]   slot;
  logic signed [31:0] cell_data [CAPACITY];
  logic signed [31:0] rd_word;
  status_e            status;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pos6 = {1'b0, in_word_i.position};
  assign cnt6 = 6'(count_q);
  assign ins_pos_ok = (pos6 != 6'd0) && (pos6 <= cnt6 + 6'd1);
  assign acc_pos_ok = (pos6 != 6'd0) && (pos6 <= cnt6);
  assign full = (cnt6 == Cap6);
  assign ins_slot6 = rev_q ? (cnt6 - (pos6 - 6'd1)) : (pos6 - 6'd1);
  assign acc_slot6 = rev_q ? (cnt6 - pos6) : (pos6 - 6'd1);

  always_comb begin
    ctrl    = '0;
    status  = STATUS_DONE;
    count_d = count_q;
    rev_d   = rev_q;
    slot    = acc_slot6[IDX_W-1:0];
    case (in_word_i.func)
      FUNC_INSERT: begin
        slot = ins_slot6[IDX_W-1:0];
        if (!ins_pos_ok) begin
          status = STATUS_BAD_POS;
        end else if (full) begin
          status = STATUS_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      FUNC_READ: begin
        if (!acc_pos_ok) begin
          status = STATUS_BAD_POS;
        end
      end
      FUNC_REMOVE: begin
        if (!acc_pos_ok) begin
          status = STATUS_BAD_POS;
        end else begin
          ctrl.rem = accept;
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
        rev_d = !rev_q;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left, right;
    if (i == 0) begin : g_first
      assign left = in_word_i.value;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    plm_cell #(
      .IDX_W(IDX_W),
      .IDX  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .slot_i (slot),
      .value_i(in_word_i.value),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i])
    );
  end

  assign rd_word = cell_data[acc_slot6[IDX_W-1:0]];

  always_comb begin
    result_d.read_value  = ((in_word_i.func == FUNC_READ) && acc_pos_ok) ? rd_word : 32'sd0;
    result_d.entry_count = 5'(count_d);
    result_d.is_empty    = (count_d == '0);
    result_d.status      = status;
    done_d               = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rev_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      if (accept) begin
        count_q <= count_d;
        rev_q   <= rev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `PLM_ASSERT_ALWAYS(a_count_bound, (!rst_ni || (6'(count_q) <= Cap6)), "entry count above capacity")
  `PLM_ASSERT(a_idle_count, (!accept |=> $stable(count_q)), "count moved without a word")
  `PLM_ASSERT(a_empty_flag, (done_o |-> (result_o.is_empty == (result_o.entry_count == 5'd0))), "empty flag disagrees with count")
  `PLM_ASSERT(a_full_refusal, ((done_o && (result_o.status == STATUS_FULL)) |-> (6'(count_q) == Cap6)), "full refusal while list not full")

endmodule

`default_nettype wire
